@@ src/gne_pkg.sv @@
package gne_pkg;

  // Fixed field widths of the channels.
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 12;
  localparam int COORD_W    = 6;
  localparam int HIN_W      = 16;
  localparam int KIND_W     = 3;
  localparam int VAL_W      = 24;
  localparam int GRID_W     = 7;
  localparam int CFG_ADDR_W = 4;
  localparam int DIR_W      = 2;
  localparam int NDIR       = 4;

  localparam int MAX_COLS_DEF    = 64;
  localparam int MAX_ROWS_DEF    = 64;
  localparam int HEIGHT_BITS_DEF = 16;

  localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXPAND   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ESTIMATE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_NEIGHBOR  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NONE      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WR_DONE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WR_REJECT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ESTIMATE  = 3'd4;

  localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 4'd1;

  localparam logic [1:0] MUL_ROW_W = 2'd0;
  localparam logic [1:0] MUL_NY_W  = 2'd1;
  localparam logic [1:0] MUL_DX_SQ = 2'd2;
  localparam logic [1:0] MUL_DY_SQ = 2'd3;

  // Neighbour order: east, south, west, north.
  localparam logic signed [1:0] STEP_DX [NDIR] = '{2'sd1, 2'sd0, -2'sd1, 2'sd0};
  localparam logic signed [1:0] STEP_DY [NDIR] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1};
  localparam logic [VAL_W-1:0]  STEP_COST [NDIR] = '{24'd1, 24'd1, 24'd1, 24'd1};

  typedef struct packed {
    logic              clear_step;
    logic              load_in;
    logic              div_start;
    logic              div_target;
    logic              cap_a;
    logic              cap_b;
    logic              mul_en;
    logic [1:0]        mul_sel;
    logic              nb_latch;
    logic              nb_addr_en;
    logic              store_wr;
    logic              est_hold;
    logic              est_sum;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic              last;
    logic [DIR_W-1:0]  dir;
  } gne_cmd_t;

  typedef struct packed {
    logic             clear_done;
    logic [CMD_W-1:0] cmd;
    logic             wr_reject;
    logic             div_done;
    logic             nb_ok;
    logic             out_free;
  } gne_stat_t;

endpackage

@@ src/gne_ifs.sv @@
interface gne_req_if import gne_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [IDX_W-1:0]         cell_index;
  logic [IDX_W-1:0]         target_index;
  logic [COORD_W-1:0]       col;
  logic [COORD_W-1:0]       row;
  logic signed [HIN_W-1:0]  new_height;

  modport source (output valid, cmd, cell_index, target_index, col, row, new_height,
                  input ready);
  modport sink (input valid, cmd, cell_index, target_index, col, row, new_height,
                output ready);
endinterface

interface gne_rsp_if import gne_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  neighbor_index;
  logic [VAL_W-1:0]  value;
  logic              last;

  modport source (output valid, kind, neighbor_index, value, last, input ready);
  modport sink (input valid, kind, neighbor_index, value, last, output ready);
endinterface

interface gne_cfg_if import gne_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [GRID_W-1:0]     data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

@@ src/gne_div.sv @@
module gne_div import gne_pkg::*; #(
  parameter int NUM_W = IDX_W,
  parameter int DEN_W = GRID_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quot,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] part;
  logic [DEN_W:0]   trial;
  logic             ge;

  // Restoring division, one quotient bit per cycle; quotient bits shift
  // into the dividend register as its bits are used up.
  assign trial = {part, num[NUM_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= '0;
      num  <= dividend;
      part <= '0;
    end else if (busy) begin
      cnt  <= cnt + 1'b1;
      num  <= {num[NUM_W-2:0], ge};
      part <= ge ? DEN_W'(trial - {1'b0, divisor}) : trial[DEN_W-1:0];
    end
  end

  assign quot = num;
  assign rem  = part;

endmodule

@@ src/gne_dpath.sv @@
module gne_dpath import gne_pkg::*; #(
  parameter int MAX_COLS    = MAX_COLS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  gne_cmd_t                ctl,
  output gne_stat_t               stat,
  input  logic [CMD_W-1:0]        req_cmd,
  input  logic [IDX_W-1:0]        req_cell,
  input  logic [IDX_W-1:0]        req_target,
  input  logic [COORD_W-1:0]      req_col,
  input  logic [COORD_W-1:0]      req_row,
  input  logic signed [HIN_W-1:0] req_height,
  input  logic                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [GRID_W-1:0]       cfg_data,
  input  logic                    rsp_ready,
  output logic                    rsp_valid,
  output logic [KIND_W-1:0]       rsp_kind,
  output logic [IDX_W-1:0]        rsp_nidx,
  output logic [VAL_W-1:0]        rsp_value,
  output logic                    rsp_last
);

  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = 2 * IDX_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int NX_W   = GRID_W + 2;
  localparam int NY_W   = IDX_W + 2;
  localparam logic [SUM_W-1:0] EST_MAX = SUM_W'((64'd1 << VAL_W) - 64'd1);

  logic [GRID_W-1:0]       grid_width, grid_height, w_eff, h_eff;
  logic [CMD_W-1:0]        in_cmd;
  logic [IDX_W-1:0]        in_cell, in_target;
  logic [COORD_W-1:0]      in_col, in_row;
  logic signed [HIN_W-1:0] in_height;

  logic                    div_done;
  logic [IDX_W-1:0]        div_quot;
  logic [GRID_W-1:0]       div_rem;
  logic [GRID_W-1:0]       ax, bx;
  logic [IDX_W-1:0]        ay, by;

  logic signed [NX_W-1:0]  nx;
  logic signed [NY_W-1:0]  ny;
  logic                    inb;
  logic [GRID_W-1:0]       nb_nx;
  logic                    nb_inb;
  logic [AW-1:0]           nb_addr [NDIR];
  logic [AW-1:0]           nb_addr_c, wr_addr_c;

  logic [IDX_W-1:0]        mul_a, mul_b;
  logic [PROD_W-1:0]       prod, sq_x;
  logic [GRID_W-1:0]       dx;
  logic [IDX_W-1:0]        dy;
  logic [SUM_W-1:0]        sum;
  logic [VAL_W-1:0]        est;

  logic [HEIGHT_BITS-1:0]  store [DEPTH];
  logic [HEIGHT_BITS-1:0]  rd_data, st_wdata, h_ext;
  logic [AW-1:0]           st_waddr;
  logic                    st_we;
  logic [AW:0]             clr_cnt;
  logic                    clear_done;

  logic                    out_valid;
  logic [IDX_W-1:0]        nidx_c;
  logic [VAL_W-1:0]        value_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= '0;
      grid_height <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sizes beyond the store clamp to its dimensions.
  assign w_eff = (32'(grid_width) > MAX_COLS) ? GRID_W'(MAX_COLS) : grid_width;
  assign h_eff = (32'(grid_height) > MAX_ROWS) ? GRID_W'(MAX_ROWS) : grid_height;

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      in_cmd    <= req_cmd;
      in_cell   <= req_cell;
      in_target <= req_target;
      in_col    <= req_col;
      in_row    <= req_row;
      in_height <= req_height;
    end
  end

  gne_div #(.NUM_W(IDX_W), .DEN_W(GRID_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (ctl.div_target ? in_target : in_cell),
    .divisor  (w_eff),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // A zero width maps every index to the origin.
  always_ff @(posedge clk) begin
    if (ctl.cap_a) begin
      ax <= (w_eff == '0) ? '0 : div_rem;
      ay <= (w_eff == '0) ? '0 : div_quot;
    end
    if (ctl.cap_b) begin
      bx <= (w_eff == '0) ? '0 : div_rem;
      by <= (w_eff == '0) ? '0 : div_quot;
    end
  end

  assign nx  = $signed({2'b00, ax}) + NX_W'(STEP_DX[ctl.dir]);
  assign ny  = $signed({2'b00, ay}) + NY_W'(STEP_DY[ctl.dir]);
  assign inb = !nx[NX_W-1] && !ny[NY_W-1] &&
               (nx[GRID_W:0] < {1'b0, w_eff}) &&
               (ny[IDX_W:0] < (IDX_W + 1)'(h_eff));

  always_ff @(posedge clk) begin
    if (ctl.nb_latch) begin
      nb_nx  <= nx[GRID_W-1:0];
      nb_inb <= inb;
    end
  end

  assign dx = (ax >= bx) ? ax - bx : bx - ax;
  assign dy = (ay >= by) ? ay - by : by - ay;

  always_comb begin
    case (ctl.mul_sel)
      MUL_ROW_W: begin
        mul_a = IDX_W'(in_row);
        mul_b = IDX_W'(w_eff);
      end
      MUL_NY_W: begin
        mul_a = ny[IDX_W-1:0];
        mul_b = IDX_W'(w_eff);
      end
      MUL_DX_SQ: begin
        mul_a = IDX_W'(dx);
        mul_b = IDX_W'(dx);
      end
      default: begin
        mul_a = dy;
        mul_b = dy;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  assign sum = {1'b0, sq_x} + {1'b0, prod};

  always_ff @(posedge clk) begin
    if (ctl.est_hold) begin
      sq_x <= prod;
    end
    if (ctl.est_sum) begin
      est <= (sum > EST_MAX) ? '1 : VAL_W'(sum);
    end
  end

  assign nb_addr_c = AW'(nb_nx) + AW'(prod);
  assign wr_addr_c = AW'(in_col) + AW'(prod);

  always_ff @(posedge clk) begin
    if (ctl.nb_addr_en) begin
      nb_addr[ctl.dir] <= nb_addr_c;
    end
  end

  // The store is swept to zero after reset, one entry a cycle.
  assign clear_done = (clr_cnt == (AW + 1)'(DEPTH));
  assign h_ext      = HEIGHT_BITS'(32'(in_height));
  assign st_we      = (ctl.clear_step && !clear_done) || ctl.store_wr;
  assign st_waddr   = ctl.clear_step ? clr_cnt[AW-1:0] : wr_addr_c;
  assign st_wdata   = ctl.clear_step ? '0 : h_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctl.clear_step && !clear_done) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store[st_waddr] <= st_wdata;
    end
    rd_data <= store[nb_addr_c];
  end

  always_comb begin
    case (ctl.kind)
      KIND_NEIGHBOR: begin
        nidx_c  = IDX_W'(nb_addr[ctl.dir]);
        value_c = STEP_COST[ctl.dir];
      end
      KIND_ESTIMATE: begin
        nidx_c  = '0;
        value_c = est;
      end
      default: begin
        nidx_c  = '0;
        value_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      rsp_kind  <= ctl.kind;
      rsp_nidx  <= nidx_c;
      rsp_value <= value_c;
      rsp_last  <= ctl.last;
    end
  end

  assign rsp_valid = out_valid;

  assign stat.clear_done = clear_done;
  assign stat.cmd        = in_cmd;
  assign stat.wr_reject  = ({1'b0, in_col} >= w_eff) || ({1'b0, in_row} >= h_eff);
  assign stat.div_done   = div_done;
  assign stat.nb_ok      = nb_inb && (rd_data != '1);
  assign stat.out_free   = !out_valid || rsp_ready;

endmodule

@@ src/gne_ctrl.sv @@
module gne_ctrl import gne_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  gne_stat_t stat,
  output gne_cmd_t  ctl
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DECODE   = 4'd2;
  localparam logic [3:0] S_WR_STORE = 4'd3;
  localparam logic [3:0] S_DIV_A    = 4'd4;
  localparam logic [3:0] S_DIV_B    = 4'd5;
  localparam logic [3:0] S_NB_MUL   = 4'd6;
  localparam logic [3:0] S_NB_ADDR  = 4'd7;
  localparam logic [3:0] S_NB_CHK   = 4'd8;
  localparam logic [3:0] S_NB_EMIT  = 4'd9;
  localparam logic [3:0] S_SQ_X     = 4'd10;
  localparam logic [3:0] S_SQ_Y     = 4'd11;
  localparam logic [3:0] S_SUM      = 4'd12;
  localparam logic [3:0] S_EMIT_ONE = 4'd13;

  logic [3:0]        state, state_next;
  logic [DIR_W-1:0]  dir, dir_next;
  logic [NDIR-1:0]   rem, rem_next;
  logic [KIND_W-1:0] kind_reg, kind_next;
  logic [DIR_W-1:0]  pick;
  logic [NDIR-1:0]   rem_clr;

  // Lowest pending direction goes out first, which keeps the
  // east, south, west, north order.
  always_comb begin
    pick = '0;
    for (int i = NDIR - 1; i >= 0; i--) begin
      if (rem[i]) begin
        pick = DIR_W'(i);
      end
    end
    rem_clr       = rem;
    rem_clr[pick] = 1'b0;
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    dir_next   = dir;
    rem_next   = rem;
    kind_next  = kind_reg;
    ctl        = '0;
    ctl.dir    = dir;
    case (state)
      S_CLEAR: begin
        ctl.clear_step = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          ctl.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        rem_next = '0;
        case (stat.cmd)
          CMD_WRITE: begin
            if (stat.wr_reject) begin
              kind_next  = KIND_WR_REJECT;
              state_next = S_EMIT_ONE;
            end else begin
              ctl.mul_en  = 1'b1;
              ctl.mul_sel = MUL_ROW_W;
              state_next  = S_WR_STORE;
            end
          end
          CMD_EXPAND, CMD_ESTIMATE: begin
            ctl.div_start = 1'b1;
            state_next    = S_DIV_A;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_WR_STORE: begin
        ctl.store_wr = 1'b1;
        kind_next    = KIND_WR_DONE;
        state_next   = S_EMIT_ONE;
      end
      S_DIV_A: begin
        if (stat.div_done) begin
          ctl.cap_a = 1'b1;
          if (stat.cmd == CMD_ESTIMATE) begin
            ctl.div_start  = 1'b1;
            ctl.div_target = 1'b1;
            state_next     = S_DIV_B;
          end else begin
            dir_next   = '0;
            state_next = S_NB_MUL;
          end
        end
      end
      S_NB_MUL: begin
        ctl.mul_en   = 1'b1;
        ctl.mul_sel  = MUL_NY_W;
        ctl.nb_latch = 1'b1;
        state_next   = S_NB_ADDR;
      end
      S_NB_ADDR: begin
        ctl.nb_addr_en = 1'b1;
        state_next     = S_NB_CHK;
      end
      S_NB_CHK: begin
        rem_next[dir] = stat.nb_ok;
        if (dir == DIR_W'(NDIR - 1)) begin
          state_next = S_NB_EMIT;
        end else begin
          dir_next   = dir + 1'b1;
          state_next = S_NB_MUL;
        end
      end
      S_NB_EMIT: begin
        if (stat.out_free) begin
          ctl.emit = 1'b1;
          ctl.last = 1'b1;
          if (rem == '0) begin
            ctl.kind   = KIND_NONE;
            state_next = S_IDLE;
          end else begin
            ctl.kind = KIND_NEIGHBOR;
            ctl.dir  = pick;
            ctl.last = (rem_clr == '0);
            rem_next = rem_clr;
            if (rem_clr == '0) begin
              state_next = S_IDLE;
            end
          end
        end
      end
      S_DIV_B: begin
        if (stat.div_done) begin
          ctl.cap_b  = 1'b1;
          state_next = S_SQ_X;
        end
      end
      S_SQ_X: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MUL_DX_SQ;
        state_next  = S_SQ_Y;
      end
      S_SQ_Y: begin
        ctl.est_hold = 1'b1;
        ctl.mul_en   = 1'b1;
        ctl.mul_sel  = MUL_DY_SQ;
        state_next   = S_SUM;
      end
      S_SUM: begin
        ctl.est_sum = 1'b1;
        kind_next   = KIND_ESTIMATE;
        state_next  = S_EMIT_ONE;
      end
      S_EMIT_ONE: begin
        if (stat.out_free) begin
          ctl.emit   = 1'b1;
          ctl.kind   = kind_reg;
          ctl.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      dir      <= '0;
      rem      <= '0;
      kind_reg <= KIND_NONE;
    end else begin
      state    <= state_next;
      dir      <= dir_next;
      rem      <= rem_next;
      kind_reg <= kind_next;
    end
  end

endmodule

@@ src/grid_neighbor_expander_core.sv @@
// Channel  Role   Word carried
// -------  -----  ------------------------------------------------------------
// req      sink   cmd, cell_index, target_index, col, row, new_height
// rsp      source kind, neighbor_index, value, last
// cfg      sink   addr (0 grid_width, 1 grid_height), data; always ready
//
// One word is processed at a time. A write stores the height unless col or row lies
// outside the grid, when it is refused; an expand and an estimate go through the index
// divider, and the single shared multiplier serves all three commands.
// After reset the height store, MAX_COLS*MAX_ROWS entries (4096 by default), is
// swept to zero and req.ready rises once the sweep is done. A stalled rsp
// holds its word; a new req word is taken while the last result still waits in rsp.
module grid_neighbor_expander_core import gne_pkg::*; #(
  parameter int MAX_COLS    = MAX_COLS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  gne_req_if.sink    req,
  gne_rsp_if.source  rsp,
  gne_cfg_if.sink    cfg
);

  gne_cmd_t  ctl;
  gne_stat_t stat;

  assign cfg.ready = 1'b1;

  gne_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  gne_dpath #(
    .MAX_COLS    (MAX_COLS),
    .MAX_ROWS    (MAX_ROWS),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .req_cmd    (req.cmd),
    .req_cell   (req.cell_index),
    .req_target (req.target_index),
    .req_col    (req.col),
    .req_row    (req.row),
    .req_height (req.new_height),
    .cfg_we     (cfg.valid && cfg.ready),
    .cfg_addr   (cfg.addr),
    .cfg_data   (cfg.data),
    .rsp_ready  (rsp.ready),
    .rsp_valid  (rsp.valid),
    .rsp_kind   (rsp.kind),
    .rsp_nidx   (rsp.neighbor_index),
    .rsp_value  (rsp.value),
    .rsp_last   (rsp.last)
  );

endmodule

@@ src/gne_checker.sv @@
module gne_checker import gne_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [KIND_W-1:0] rsp_kind,
  input logic [IDX_W-1:0]  rsp_nidx,
  input logic [VAL_W-1:0]  rsp_value,
  input logic              rsp_last
);

  // The block works on one word at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req ready right after an accepted word");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_nidx) && $stable(rsp_value) && $stable(rsp_last))
    else $error("stalled result word changed");

  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind != KIND_NEIGHBOR |-> rsp_last && rsp_nidx == '0)
    else $error("single result word not marked last or carries an index");

  a_step_cost: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind == KIND_NEIGHBOR |-> rsp_value == 24'd1)
    else $error("neighbour word with wrong step cost");

endmodule

bind grid_neighbor_expander_core gne_checker u_gne_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_kind  (rsp.kind),
  .rsp_nidx  (rsp.neighbor_index),
  .rsp_value (rsp.value),
  .rsp_last  (rsp.last)
);

@@ dv/grid_expand_checker.sv @@
module grid_expand_checker import gne_pkg::*; (
  input  logic clk,
  input  logic rst,
  gne_req_if   req,
  gne_rsp_if   rsp,
  gne_cfg_if   cfg,
  output int   fail_tally,
  output int   words_owed
);

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  nidx;
    logic [VAL_W-1:0]  value;
    logic              last;
  } grid_word_t;

  typedef enum int {HEAD_EAST, HEAD_SOUTH, HEAD_WEST, HEAD_NORTH} heading_t;

  localparam int STORE_CELLS = MAX_COLS_DEF * MAX_ROWS_DEF;
  localparam logic [VAL_W-1:0] STEP_PRICE = 24'd1;
  localparam longint DIST_CEILING = 64'hFF_FFFF;

  grid_word_t owed_words[$];
  logic [HEIGHT_BITS_DEF-1:0] height_mirror [STORE_CELLS];
  logic [GRID_W-1:0] cols_cfg;
  logic [GRID_W-1:0] rows_cfg;

  function automatic int used_cols();
    return (cols_cfg > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_cfg);
  endfunction

  function automatic int used_rows();
    return (rows_cfg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_cfg);
  endfunction

  // A zero width sends every index to the origin.
  function automatic void split_cell(input int idx, output int cx, output int cy);
    int w;
    w = used_cols();
    if (w == 0) begin
      cx = 0;
      cy = 0;
    end else begin
      cx = idx % w;
      cy = idx / w;
    end
  endfunction

  function automatic void owe(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] nidx,
                              input logic [VAL_W-1:0] value, input logic last);
    grid_word_t w;
    w.kind  = kind;
    w.nidx  = nidx;
    w.value = value;
    w.last  = last;
    owed_words.push_back(w);
  endfunction

  task automatic note_mismatch(input string msg);
    $display("[%0t] grid checker mismatch: %s", $time, msg);
    fail_tally++;
  endtask

  task automatic predict_grid_words(input logic [CMD_W-1:0] op,
                                    input logic [IDX_W-1:0] cell_idx,
                                    input logic [IDX_W-1:0] target,
                                    input logic [COORD_W-1:0] col,
                                    input logic [COORD_W-1:0] row,
                                    input logic [HIN_W-1:0] hgt);
    int w, h, cx, cy, tx, ty, nx, ny, hits, d, k;
    logic [IDX_W-1:0] found [NDIR];
    logic signed [31:0] wide;
    longint sq_dist;
    w = used_cols();
    h = used_rows();
    hits = 0;
    case (op)
      CMD_WRITE: begin
        if (int'(col) >= w || int'(row) >= h) begin
          owe(KIND_WR_REJECT, '0, '0, 1'b1);
        end else begin
          wide = signed'(hgt);
          height_mirror[int'(col) + int'(row) * w] = wide[HEIGHT_BITS_DEF-1:0];
          owe(KIND_WR_DONE, '0, '0, 1'b1);
        end
      end
      CMD_EXPAND: begin
        split_cell(int'(cell_idx), cx, cy);
        for (d = 0; d < NDIR; d++) begin
          nx = cx;
          ny = cy;
          case (heading_t'(d))
            HEAD_EAST:  nx = cx + 1;
            HEAD_SOUTH: ny = cy + 1;
            HEAD_WEST:  nx = cx - 1;
            HEAD_NORTH: ny = cy - 1;
            default: ;
          endcase
          if (nx >= 0 && ny >= 0 && nx < w && ny < h) begin
            if (height_mirror[nx + ny * w] != '1) begin
              found[hits] = IDX_W'(nx + ny * w);
              hits++;
            end
          end
        end
        if (hits == 0) begin
          owe(KIND_NONE, '0, '0, 1'b1);
        end else begin
          for (k = 0; k < hits; k++) begin
            owe(KIND_NEIGHBOR, found[k], STEP_PRICE, k == hits - 1);
          end
        end
      end
      CMD_ESTIMATE: begin
        split_cell(int'(cell_idx), cx, cy);
        split_cell(int'(target), tx, ty);
        sq_dist = longint'(cx - tx) * longint'(cx - tx) + longint'(cy - ty) * longint'(cy - ty);
        if (sq_dist > DIST_CEILING) begin
          sq_dist = DIST_CEILING;
        end
        owe(KIND_ESTIMATE, '0, sq_dist[VAL_W-1:0], 1'b1);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch_channels
    grid_word_t want;
    if (rst) begin
      cols_cfg = '0;
      rows_cfg = '0;
      for (int i = 0; i < STORE_CELLS; i++) begin
        height_mirror[i] = '0;
      end
      owed_words.delete();
      fail_tally = 0;
    end else begin
      // Results are retired before the word taken at the same edge is predicted.
      if (rsp.valid && rsp.ready) begin
        if (owed_words.size() == 0) begin
          note_mismatch($sformatf("result word with nothing owed: kind %0d index %0d value %0d",
                                  rsp.kind, rsp.neighbor_index, rsp.value));
        end else begin
          want = owed_words.pop_front();
          if (rsp.kind !== want.kind) begin
            note_mismatch($sformatf("kind %0d, expected %0d", rsp.kind, want.kind));
          end
          if (rsp.neighbor_index !== want.nidx) begin
            note_mismatch($sformatf("neighbor_index %0d, expected %0d",
                                    rsp.neighbor_index, want.nidx));
          end
          if (rsp.value !== want.value) begin
            note_mismatch($sformatf("value %0d, expected %0d", rsp.value, want.value));
          end
          if (rsp.last !== want.last) begin
            note_mismatch($sformatf("last %0b, expected %0b", rsp.last, want.last));
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.addr)
          REG_GRID_WIDTH:  cols_cfg = cfg.data;
          REG_GRID_HEIGHT: rows_cfg = cfg.data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        predict_grid_words(req.cmd, req.cell_index, req.target_index, req.col, req.row,
                           req.new_height);
      end
    end
    words_owed <= owed_words.size();
  end

endmodule

@@ dv/grid_neighbor_expander_core_tb.sv @@
module grid_neighbor_expander_core_tb import gne_pkg::*; ();

  localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
  localparam int SETTLE_CYCLES   = 64;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASE_WORDS     = 35;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   owed;
  int   burst_left;
  int   cols_eff;
  int   rows_eff;
  bit   choke_rsp;
  int   recent_cells[$];

  gne_req_if req();
  gne_rsp_if rsp();
  gne_cfg_if cfg();

  grid_neighbor_expander_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  grid_expand_checker watch (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .cfg        (cfg),
    .fail_tally (fail_count),
    .words_owed (owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("grid_neighbor_expander_core regression: fail");
    $finish;
  end

  // The receiver switches between random stall patterns; a requested
  // hold-off keeps it stalled long enough for the block to stop taking words.
  initial begin
    int mode;
    int span;
    int held;
    rsp.ready <= 1'b0;
    mode = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (choke_rsp) begin
        rsp.ready <= 1'b0;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) begin
          @(posedge clk);
        end
        choke_rsp = 1'b0;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(5, 60);
      end
      span--;
      case (mode)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= 1'($urandom_range(0, 1));
        2: rsp.ready <= ($urandom_range(0, 3) == 0);
        default: rsp.ready <= (span % 3 == 0);
      endcase
    end
  end

  task automatic send_word(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] cell_idx,
                           input logic [IDX_W-1:0] target, input logic [COORD_W-1:0] col,
                           input logic [COORD_W-1:0] row, input logic [HIN_W-1:0] hgt);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
    req.valid        <= 1'b1;
    req.cmd          <= op;
    req.cell_index   <= cell_idx;
    req.target_index <= target;
    req.col          <= col;
    req.row          <= row;
    req.new_height   <= hgt;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic set_grid(input logic [GRID_W-1:0] w, input logic [GRID_W-1:0] h);
    cfg.valid <= 1'b1;
    cfg.addr  <= REG_GRID_WIDTH;
    cfg.data  <= w;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.addr <= REG_GRID_HEIGHT;
    cfg.data <= h;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    cols_eff = (w > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(w);
    rows_eff = (h > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(h);
    recent_cells.delete();
  endtask

  // An ignored command gives no result word, so settle also waits out a
  // settling period once everything owed has come back.
  task automatic settle();
    req.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_word(output bit counted);
    int pick;
    int area;
    int base;
    int probe;
    logic [CMD_W-1:0]   op;
    logic [IDX_W-1:0]   cell_idx;
    logic [IDX_W-1:0]   target;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [HIN_W-1:0]   hgt;
    area     = cols_eff * rows_eff;
    cell_idx = IDX_W'($urandom);
    target   = IDX_W'($urandom);
    col      = COORD_W'($urandom);
    row      = COORD_W'($urandom);
    hgt      = HIN_W'($urandom);
    counted  = 1'b1;
    pick     = $urandom_range(0, 99);
    if (pick < 5) begin
      op = CMD_IGNORED;
      counted = 1'b0;
    end else if (pick < 40) begin
      op = CMD_WRITE;
      if (area > 0 && $urandom_range(0, 4) != 0) begin
        col = COORD_W'($urandom_range(0, cols_eff - 1));
        row = COORD_W'($urandom_range(0, rows_eff - 1));
        recent_cells.push_back(int'(col) + int'(row) * cols_eff);
        if (recent_cells.size() > 8) begin
          void'(recent_cells.pop_front());
        end
      end
      case ($urandom_range(0, 9))
        0, 1, 2: hgt = '1;
        3:       hgt = '0;
        default: ;
      endcase
    end else if (pick < 80) begin
      op = CMD_EXPAND;
      // Some expands pick cells next to recent writes, where blocked cells sit.
      if (area > 0 && $urandom_range(0, 5) != 0) begin
        if (recent_cells.size() > 0 && $urandom_range(0, 1) == 1) begin
          base = recent_cells[$urandom_range(0, recent_cells.size() - 1)];
          case ($urandom_range(0, 4))
            0:       probe = base + 1;
            1:       probe = base - 1;
            2:       probe = base + cols_eff;
            3:       probe = base - cols_eff;
            default: probe = base;
          endcase
          if (probe < 0 || probe >= area) begin
            probe = base;
          end
          cell_idx = IDX_W'(probe);
        end else begin
          cell_idx = IDX_W'($urandom_range(0, area - 1));
        end
      end
    end else begin
      op = CMD_ESTIMATE;
      if (area > 0 && $urandom_range(0, 1) == 1) begin
        cell_idx = IDX_W'($urandom_range(0, area - 1));
        target   = IDX_W'($urandom_range(0, area - 1));
      end
    end
    send_word(op, cell_idx, target, col, row, hgt);
  endtask

  initial begin
    int  phase;
    int  done;
    bit  counted;
    logic [GRID_W-1:0] w;
    logic [GRID_W-1:0] h;
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.cmd          <= CMD_WRITE;
    req.cell_index   <= '0;
    req.target_index <= '0;
    req.col          <= '0;
    req.row          <= '0;
    req.new_height   <= '0;
    cfg.valid        <= 1'b0;
    cfg.addr         <= REG_GRID_WIDTH;
    cfg.data         <= '0;
    burst_left = 0;
    choke_rsp  = 1'b0;
    cols_eff   = 0;
    rows_eff   = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty grid: everything maps to the origin and every write is refused.
    set_grid(7'd0, 7'd0);
    send_word(CMD_EXPAND, 12'd0, 12'd0, 6'd0, 6'd0, 16'h0000);
    send_word(CMD_ESTIMATE, 12'd4095, 12'd7, 6'd0, 6'd0, 16'h0000);
    send_word(CMD_WRITE, 12'd0, 12'd0, 6'd0, 6'd0, 16'h1234);
    settle();

    // A 4 by 3 grid with blocked cells, corners and bound edges.
    set_grid(7'd4, 7'd3);
    send_word(CMD_WRITE, 12'd0, 12'd0, 6'd1, 6'd0, 16'hFFFF);
    send_word(CMD_WRITE, 12'd0, 12'd0, 6'd3, 6'd2, 16'h7FFF);
    send_word(CMD_WRITE, 12'd0, 12'd0, 6'd0, 6'd0, 16'h8000);
    send_word(CMD_WRITE, 12'd0, 12'd0, 6'd4, 6'd0, 16'h0001);
    send_word(CMD_WRITE, 12'd0, 12'd0, 6'd0, 6'd3, 16'h0001);
    send_word(CMD_WRITE, 12'd0, 12'd0, 6'd63, 6'd63, 16'h0001);
    send_word(CMD_EXPAND, 12'd0, 12'd0, 6'd0, 6'd0, 16'h0000);
    send_word(CMD_EXPAND, 12'd5, 12'd0, 6'd0, 6'd0, 16'h0000);
    send_word(CMD_EXPAND, 12'd6, 12'd0, 6'd0, 6'd0, 16'h0000);
    send_word(CMD_EXPAND, 12'd11, 12'd0, 6'd0, 6'd0, 16'h0000);
    send_word(CMD_EXPAND, 12'd13, 12'd0, 6'd0, 6'd0, 16'h0000);
    send_word(CMD_EXPAND, 12'd4095, 12'd0, 6'd0, 6'd0, 16'h0000);
    send_word(CMD_ESTIMATE, 12'd0, 12'd11, 6'd0, 6'd0, 16'h0000);
    send_word(CMD_ESTIMATE, 12'd4095, 12'd0, 6'd0, 6'd0, 16'h0000);
    send_word(CMD_IGNORED, 12'hFFF, 12'hFFF, 6'd63, 6'd63, 16'hFFFF);
    send_word(CMD_WRITE, 12'd0, 12'd0, 6'd3, 6'd2, 16'hFFFF);
    send_word(CMD_EXPAND, 12'd7, 12'd0, 6'd0, 6'd0, 16'h0000);
    send_word(CMD_WRITE, 12'd0, 12'd0, 6'd0, 6'd1, 16'hFFFF);
    send_word(CMD_EXPAND, 12'd0, 12'd0, 6'd0, 6'd0, 16'h0000);

    for (phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0:       begin w = 7'd8;   h = 7'd8;   end
        1:       begin w = 7'd64;  h = 7'd64;  end
        2:       begin w = 7'd5;   h = 7'd3;   end
        3:       begin w = 7'd127; h = 7'd127; end
        4:       begin w = 7'd1;   h = 7'd127; end
        5:       begin w = 7'd0;   h = 7'd9;   end
        6:       begin w = 7'd6;   h = 7'd0;   end
        default: begin
          w = GRID_W'($urandom_range(1, 64));
          h = GRID_W'($urandom_range(1, 64));
        end
      endcase
      set_grid(w, h);
      done = 0;
      while (done < PHASE_WORDS) begin
        if (phase == 2 && done == 5) begin
          choke_rsp = 1'b1;
        end
        random_word(counted);
        if (counted) begin
          done++;
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("grid_neighbor_expander_core regression: pass");
    end else begin
      $display("grid_neighbor_expander_core regression: fail");
    end
    $finish;
  end

endmodule
